>>> rtl/core/okm_pkg.sv
// okm_pkg: shared types and constants for online_kmeans_update
// no dependencies
package okm_pkg;

   localparam int CoordW = 16;
   localparam int WeightW = 32;
   localparam int DistW = 37;
   localparam int FfW = 17;
   localparam logic [FfW-1:0] FfOne = 17'd65536;
   localparam logic [WeightW-1:0] OneQ16 = 32'd65536;

   typedef enum logic [1:0] {
      ACT_LOAD_COORD  = 2'd0,
      ACT_LOAD_WEIGHT = 2'd1,
      ACT_SAMPLE      = 2'd2,
      ACT_NONE        = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         cluster_index;
      logic [2:0]         coord_index;
      logic signed [15:0] coord_value;
      logic [31:0]        initial_weight;
      logic               last_coord;
   } req_type;

   typedef struct packed {
      logic [3:0]  nearest_cluster;
      logic [36:0] nearest_distance;
      logic [31:0] updated_weight;
   } rsp_type;

   localparam logic [1:0] RegFf = 2'd0;
   localparam logic [1:0] RegClusters = 2'd1;
   localparam logic [1:0] RegDims = 2'd2;

endpackage

>>> rtl/core/okm_cell.sv
// okm_cell: one cluster cell, holds one centroid and weight
// depends on okm_pkg
module okm_cell
   import okm_pkg::*;
#(
   parameter int DIMS = 8,
   parameter int DW = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     coord_we,
   input  logic [DW-1:0]            coord_addr,
   input  logic signed [CoordW-1:0] coord_wdata,
   input  logic                     weight_we,
   input  logic [WeightW-1:0]       weight_wdata,
   input  logic                     rot,
   input  logic                     upd_we,
   input  logic signed [CoordW-1:0] upd_data,
   input  logic signed [CoordW-1:0] x_in,
   input  logic                     acc_clr,
   input  logic                     acc_en,
   output logic signed [CoordW-1:0] head,
   output logic [WeightW-1:0]       weight,
   output logic [47:0]              sq_dist
);
   logic signed [CoordW-1:0] c_ff [DIMS];
   logic [WeightW-1:0] w_ff;
   logic [47:0] acc_ff;
   logic signed [CoordW:0] diff;
   logic [CoordW:0] mag;
   logic [2*CoordW+1:0] sq;

   assign head = c_ff[0];
   assign weight = w_ff;
   assign sq_dist = acc_ff;
   assign diff = {x_in[CoordW-1], x_in} - {c_ff[0][CoordW-1], c_ff[0]};
   assign mag = diff[CoordW] ? -diff : diff;
   assign sq = mag * mag;

   // centroid circulates as a ring; rot moves it by one place
   // on an update the head leaves with its new value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIMS; i++) c_ff[i] <= '0;
         w_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (rot) begin
            for (int i = 0; i < DIMS - 1; i++) c_ff[i] <= c_ff[i+1];
            c_ff[DIMS-1] <= upd_we ? upd_data : c_ff[0];
         end else if (coord_we) begin
            c_ff[coord_addr] <= coord_wdata;
         end
         if (weight_we) w_ff <= weight_wdata;
         if (acc_clr) acc_ff <= '0;
         else if (acc_en) acc_ff <= acc_ff + 48'(sq);
      end
   end
endmodule

>>> rtl/core/okm_divider.sv
// okm_divider: restoring divider, one quotient bit a cycle
// depends on nothing
module okm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [32:0] quo
);
   logic [32:0] q_ff;
   logic [32:0] r_ff;
   logic [5:0]  n_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [33:0] trial;

   assign trial = {r_ff, q_ff[32]};
   assign quo = q_ff;
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff <= num;
            r_ff <= '0;
            n_ff <= 6'd33;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {2'b0, den}) begin
               r_ff <= 33'(trial - {2'b0, den});
               q_ff <= {q_ff[31:0], 1'b1};
            end else begin
               r_ff <= trial[32:0];
               q_ff <= {q_ff[31:0], 1'b0};
            end
            n_ff <= n_ff - 6'd1;
            if (n_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

>>> rtl/core/online_kmeans_update.sv
// online_kmeans_update: top level, chain of cluster cells with sequencer
// depends on okm_pkg, okm_cell, okm_divider
// load items and non-final sample items are taken back to back
// a final sample coordinate starts the result: a distance scan of the ring, the search,
// the weight update, one division a coordinate in the shared divider, each followed by
// a rotation, then a realign of the rings when fewer than DIMS coordinates are active
// one item at a time; no item is taken while a result waits in the output register
// synchronous reset: centroids and weights cleared, registers to defaults
module online_kmeans_update
   import okm_pkg::*;
#(
   parameter int CLUSTERS = 16,
   parameter int DIMS = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data,
   input  logic           psel,
   input  logic           penable,
   input  logic           pwrite,
   input  logic [3:0]     paddr,
   input  logic [31:0]    pwdata,
   output logic [31:0]    prdata,
   output logic           pready
);
   localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int CW = $clog2(CLUSTERS);
   localparam int DCW = $clog2(DIMS + 1);
   localparam int KCW = $clog2(CLUSTERS + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_DIST = 6'b000010, ST_REALIGN = 6'b000100,
      ST_SEARCH = 6'b001000, ST_WEIGHT = 6'b010000, ST_UPDATE = 6'b100000
   } state_type;

   state_type st_ff;
   logic [FfW-1:0] ff_ff;
   logic [4:0] ncl_ff;
   logic [3:0] ndm_ff;
   logic signed [CoordW-1:0] pb_ff [DIMS];
   logic [DCW-1:0] cnt_ff;
   logic [KCW-1:0] srch_ff;
   logic [CW-1:0] best_ff;
   logic [47:0] bdist_ff;
   logic [WeightW-1:0] nw_ff;
   logic [1:0] sub_ff;
   logic [48:0] prod_ff;
   logic kick_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [DCW-1:0] nd;
   logic [KCW-1:0] nk;
   logic [FfW-1:0] ffe;
   logic signed [CoordW-1:0] head [CLUSTERS];
   logic [WeightW-1:0] wt [CLUSTERS];
   logic [47:0] sq_dist [CLUSTERS];
   logic [47:0] cand_dist;
   logic [48:0] wprod;
   logic rot, acc_clr, acc_en, dv_start, dv_done;
   logic [32:0] dv_num, dv_quo;
   logic signed [CoordW:0] udiff;
   logic [CoordW-1:0] newc;
   logic accept, ld_c, ld_w;
   logic signed [CoordW-1:0] x_cur;

   // clamp registers into their working ranges
   assign nd = (ndm_ff == 4'd0) ? DCW'(1) :
               ({28'd0, ndm_ff} > DIMS) ? DCW'(DIMS) : DCW'(ndm_ff);
   assign nk = (ncl_ff == 5'd0) ? KCW'(1) :
               ({27'd0, ncl_ff} > CLUSTERS) ? KCW'(CLUSTERS) : KCW'(ncl_ff);
   assign ffe = (ff_ff > FfOne) ? FfOne : ff_ff;

   assign req_ready = (st_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign ld_c = accept && req_data.action == ACT_LOAD_COORD
                 && {28'd0, req_data.coord_index} < DIMS;
   assign ld_w = accept && req_data.action == ACT_LOAD_WEIGHT
                 && {28'd0, req_data.cluster_index} < CLUSTERS;

   // the point buffer rotates alongside the centroid rings
   assign x_cur = pb_ff[0];
   assign rot = (st_ff == ST_DIST) || (st_ff == ST_REALIGN)
                || (st_ff == ST_UPDATE && dv_done);
   assign acc_clr = accept;
   assign acc_en = (st_ff == ST_DIST) && (cnt_ff < nd);

   for (genvar k = 0; k < CLUSTERS; k++) begin : g_cell
      logic upd;
      assign upd = (st_ff == ST_UPDATE) && dv_done && best_ff == CW'(k);
      okm_cell #(.DIMS(DIMS), .DW(DW)) u_cell (
         .clock, .reset,
         .coord_we(ld_c && 32'(req_data.cluster_index) == k),
         .coord_addr(DW'(req_data.coord_index)),
         .coord_wdata(req_data.coord_value),
         .weight_we((ld_w && 32'(req_data.cluster_index) == k)
                    || (st_ff == ST_WEIGHT && sub_ff == 2'd2 && best_ff == CW'(k))),
         .weight_wdata(ld_w ? req_data.initial_weight : nw_ff),
         .rot(rot),
         .upd_we(upd), .upd_data(newc),
         .x_in(x_cur), .acc_clr, .acc_en,
         .head(head[k]), .weight(wt[k]), .sq_dist(sq_dist[k])
      );
   end

   // best so far; cluster 0 seeds the search on its first step
   assign cand_dist = (srch_ff == KCW'(1)) ? sq_dist[0] : bdist_ff;
   assign wprod = wt[best_ff] * ffe;

   // update step on the winner's head coordinate; the divider restarts in the
   // cycle after each rotation so that the next coordinate is at the head
   assign udiff = {x_cur[CoordW-1], x_cur} - {head[best_ff][CoordW-1], head[best_ff]};
   assign dv_num = {udiff[CoordW] ? 17'(-udiff) : 17'(udiff), 16'd0};
   assign newc = udiff[CoordW] ? head[best_ff] - dv_quo[CoordW-1:0]
                               : head[best_ff] + dv_quo[CoordW-1:0];
   assign dv_start = (st_ff == ST_WEIGHT && sub_ff == 2'd3) || kick_ff;

   okm_divider u_div (.clock, .reset, .start(dv_start), .num(dv_num),
                      .den(nw_ff), .done(dv_done), .quo(dv_quo));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ff_ff <= FfOne;
         ncl_ff <= 5'd16;
         ndm_ff <= 4'd8;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         srch_ff <= '0;
         sub_ff <= '0;
         kick_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               RegFf:       ff_ff <= pwdata[FfW-1:0];
               RegClusters: ncl_ff <= pwdata[4:0];
               RegDims:     ndm_ff <= pwdata[3:0];
               default:     ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         kick_ff <= (st_ff == ST_UPDATE) && dv_done && (cnt_ff + DCW'(1) < nd);
         case (st_ff)
            ST_IDLE: begin
               if (accept && req_data.action == ACT_SAMPLE) begin
                  if ({28'd0, req_data.coord_index} < DIMS)
                     pb_ff[DW'(req_data.coord_index)] <= req_data.coord_value;
                  if (req_data.last_coord) begin
                     st_ff <= ST_DIST;
                     cnt_ff <= '0;
                  end
               end
            end
            ST_DIST: begin
               for (int i = 0; i < DIMS - 1; i++) pb_ff[i] <= pb_ff[i+1];
               pb_ff[DIMS-1] <= pb_ff[0];
               cnt_ff <= cnt_ff + DCW'(1);
               if (cnt_ff == DCW'(DIMS - 1)) st_ff <= ST_SEARCH;
               srch_ff <= KCW'(1);
               best_ff <= '0;
            end
            ST_SEARCH: begin
               // strict compare keeps the lower index on a tie
               if (srch_ff < nk && sq_dist[CW'(srch_ff)] < cand_dist) begin
                  bdist_ff <= sq_dist[CW'(srch_ff)];
                  best_ff <= CW'(srch_ff);
               end else begin
                  bdist_ff <= cand_dist;
               end
               if (srch_ff < nk) begin
                  srch_ff <= srch_ff + KCW'(1);
               end else begin
                  st_ff <= ST_WEIGHT;
                  sub_ff <= '0;
               end
            end
            ST_WEIGHT: begin
               sub_ff <= sub_ff + 2'd1;
               if (sub_ff == 2'd0) prod_ff <= wprod;
               if (sub_ff == 2'd1)
                  nw_ff <= ({1'b0, prod_ff[47:16]} + {1'b0, OneQ16}) > 33'hFFFF_FFFF ?
                           32'hFFFF_FFFF : 32'(prod_ff[47:16] + {16'd0, OneQ16});
               if (sub_ff == 2'd3) begin
                  st_ff <= ST_UPDATE;
                  cnt_ff <= '0;
               end
            end
            ST_UPDATE: begin
               if (dv_done) begin
                  for (int i = 0; i < DIMS - 1; i++) pb_ff[i] <= pb_ff[i+1];
                  pb_ff[DIMS-1] <= pb_ff[0];
                  cnt_ff <= cnt_ff + DCW'(1);
                  if (cnt_ff + DCW'(1) >= nd) begin
                     if (cnt_ff + DCW'(1) == DCW'(DIMS)) begin
                        st_ff <= ST_IDLE;
                        rsp_valid_ff <= 1'b1;
                        rsp_ff.nearest_cluster <= 4'(best_ff);
                        rsp_ff.nearest_distance <= (bdist_ff > 48'h1F_FFFF_FFFF) ?
                           37'h1F_FFFF_FFFF : bdist_ff[36:0];
                        rsp_ff.updated_weight <= nw_ff;
                     end else st_ff <= ST_REALIGN;
                  end
               end
            end
            ST_REALIGN: begin
               for (int i = 0; i < DIMS - 1; i++) pb_ff[i] <= pb_ff[i+1];
               pb_ff[DIMS-1] <= pb_ff[0];
               cnt_ff <= cnt_ff + DCW'(1);
               if (cnt_ff + DCW'(1) == DCW'(DIMS)) begin
                  st_ff <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.nearest_cluster <= 4'(best_ff);
                  rsp_ff.nearest_distance <= (bdist_ff > 48'h1F_FFFF_FFFF) ?
                     37'h1F_FFFF_FFFF : bdist_ff[36:0];
                  rsp_ff.updated_weight <= nw_ff;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign pready = 1'b1;
   always_comb begin
      case (paddr[3:2])
         RegFf:       prdata = {15'd0, ff_ff};
         RegClusters: prdata = {27'd0, ncl_ff};
         RegDims:     prdata = {28'd0, ndm_ff};
         default:     prdata = '0;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_one_state: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
endmodule
